// ===== src/grs_pkg.sv =====
package grs_pkg;

  localparam int unsigned MAX_GROUP_DEF  = 16;
  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned CFG_WIDTH      = 5;

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } grs_state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_final;
  } grs_cmd_t;

endpackage

// ===== src/grs_in_if.sv =====
interface grs_in_if #(
  parameter int unsigned DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] word_in;
  logic                  ends_sequence;

  modport source (output valid, output word_in, output ends_sequence, input ready);
  modport sink   (input valid, input word_in, input ends_sequence, output ready);
endinterface

// ===== src/grs_out_if.sv =====
interface grs_out_if #(
  parameter int unsigned DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] word_out;
  logic                  final_out;

  modport source (output valid, output word_out, output final_out, input ready);
  modport sink   (input valid, input word_out, input final_out, output ready);
endinterface

// ===== src/grs_ctrl.sv =====
module grs_ctrl #(
  parameter int unsigned MAX_GROUP = grs_pkg::MAX_GROUP_DEF,
  localparam int unsigned AW = $clog2(MAX_GROUP),
  localparam int unsigned CW = $clog2(MAX_GROUP + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [grs_pkg::CFG_WIDTH-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_last_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output grs_pkg::grs_cmd_t              cmd_o,
  output logic [AW-1:0]                  wr_addr_o,
  output logic [AW-1:0]                  rd_addr_o
);
  import grs_pkg::*;

  localparam int unsigned KW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

  grs_state_e           state_q, state_d;
  logic [CFG_WIDTH-1:0] group_size_q;
  logic [AW-1:0]        fill_q, fill_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic                 rev_q, rev_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;

  logic [KW-1:0]        k_eff;
  logic [CW-1:0]        n;
  logic                 full;
  logic                 accept;

  always_comb begin
    if (group_size_q == '0) begin
      k_eff = KW'(1);
    end else if (KW'(group_size_q) > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = KW'(group_size_q);
    end
  end

  assign n      = CW'(fill_q) + CW'(1);
  assign full   = KW'(n) >= k_eff;
  assign accept = in_valid_i && (state_q == ST_FILL);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    addr_d       = addr_q;
    rem_d        = rem_q;
    rev_d        = rev_q;
    last_d       = last_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        in_ready_o  = 1'b1;
        cmd_o.wr_en = accept;
        if (accept) begin
          if (full || in_last_i) begin
            state_d = ST_EMIT;
            fill_d  = '0;
            rem_d   = n;
            rev_d   = full;
            last_d  = in_last_i;
            addr_d  = full ? fill_q : '0;
          end else begin
            fill_d = fill_q + AW'(1);
          end
        end
      end
      ST_EMIT: begin
        cmd_o.rd_en    = !out_valid_q || out_ready_i;
        cmd_o.rd_final = last_q && (rem_q == CW'(1));
        if (cmd_o.rd_en) begin
          rem_d  = rem_q - CW'(1);
          addr_d = rev_q ? addr_q - AW'(1) : addr_q + AW'(1);
          if (rem_q == CW'(1)) begin
            state_d = ST_FILL;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.rd_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign wr_addr_o   = fill_q;
  assign rd_addr_o   = addr_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      group_size_q <= CFG_WIDTH'(1);
      fill_q       <= '0;
      addr_q       <= '0;
      rem_q        <= '0;
      rev_q        <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      addr_q      <= addr_d;
      rem_q       <= rem_d;
      rev_q       <= rev_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== src/grs_datapath.sv =====
module grs_datapath #(
  parameter int unsigned MAX_GROUP  = grs_pkg::MAX_GROUP_DEF,
  parameter int unsigned DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_GROUP)
) (
  input  logic                  clk_i,
  input  grs_pkg::grs_cmd_t     cmd_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [AW-1:0]         rd_addr_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  output logic [DATA_WIDTH-1:0] word_o,
  output logic                  final_o
);
  import grs_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [MAX_GROUP];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  final_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= word_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
      final_q   <= cmd_i.rd_final;
    end
  end

  assign word_o  = rd_data_q;
  assign final_o = final_q;

endmodule

// ===== src/group_reverse_stream_top.sv =====
// group reverse stream
// in_i carries words with an end-of-sequence mark; out_o carries the
// reordered words, final_out marking the last word of each sequence.
// cfg_we_i/cfg_wdata_i set the group size k (0 acts as 1, values above
// MAX_GROUP act as MAX_GROUP); write it only while the block is idle.
// each accepted word is written to the group buffer, one per cycle.
// when k words are held the group is read back newest first; when a word
// marked end-of-sequence closes a shorter group it is read back in order.
// no request is accepted while a group is being read back.
// the first word of a group is valid on out_o after the state register enters
// read back and the registered buffer read loads the output register, then
// one word per cycle while out_o is ready; input waits during read back.
// a stall on out_o holds the output register and pauses buffer reads;
// once the last read of a group is issued new requests are taken again.
// reset empties the buffer count, drops out_o.valid and sets k to 1.
module group_reverse_stream_top #(
  parameter int unsigned MAX_GROUP  = grs_pkg::MAX_GROUP_DEF,
  parameter int unsigned DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [grs_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  grs_in_if.sink                        in_i,
  grs_out_if.source                     out_o
);
  import grs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_GROUP);

  grs_cmd_t      cmd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  grs_ctrl #(
    .MAX_GROUP(MAX_GROUP)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.ends_sequence),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr)
  );

  grs_datapath #(
    .MAX_GROUP (MAX_GROUP),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .word_i    (in_i.word_in),
    .word_o    (out_o.word_out),
    .final_o   (out_o.final_out)
  );

endmodule
